/* rtl/core/lag_pkg.sv */
// shared types and constants for the life automaton grid
package lag_pkg;

   localparam int DEF_GRID_ROWS = 64;
   localparam int DEF_GRID_COLS = 64;
   localparam int ADDR_W        = 6;
   localparam int NBR_W         = 4;

   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NBR_W-1:0] STAY_COUNT  = 4'd2;

   typedef enum logic [1:0] {
      FUNC_SET     = 2'd0,
      FUNC_CLEAR   = 2'd1,
      FUNC_ADVANCE = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CELL,
      ST_ADVANCE,
      ST_FINISH
   } state_type;

   // one column of the three-row window
   typedef struct packed {
      logic above;
      logic mid;
      logic below;
   } col_window_type;

endpackage

/* rtl/core/lag_if.sv */
// request and response channel interfaces
interface lag_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                func;
   logic [lag_pkg::ADDR_W-1:0] cell_row;
   logic [lag_pkg::ADDR_W-1:0] cell_col;

   modport source (output valid, output func, output cell_row, output cell_col, input ready);
   modport sink   (input valid, input func, input cell_row, input cell_col, output ready);
endinterface

interface lag_rsp_if;
   logic valid;
   logic ready;
   logic alive;
   logic was_alive;

   modport source (output valid, output alive, output was_alive, input ready);
   modport sink   (input valid, input alive, input was_alive, output ready);
endinterface

/* rtl/core/lag_row_store.sv */
// row-wide grid memory with per-row valid bits, reads dead for unwritten rows
module lag_row_store #(
   parameter int ROWS = lag_pkg::DEF_GRID_ROWS,
   parameter int COLS = lag_pkg::DEF_GRID_COLS,
   localparam int ROW_W = $clog2(ROWS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_addr,
   output logic [COLS-1:0]  rd_data,
   input  logic             wr_en,
   input  logic [ROW_W-1:0] wr_addr,
   input  logic [COLS-1:0]  wr_data
);

   logic [COLS-1:0] mem [ROWS];
   logic [ROWS-1:0] row_valid_ff;
   logic [COLS-1:0] rd_raw_ff;
   logic            rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff     <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_ok_ff ? rd_raw_ff : '0;

endmodule

/* rtl/core/lag_cell.sv */
// one column cell: holds the upper two window rows and applies the b3/s23 rule
module lag_cell (
   input  logic                    clock,
   input  logic                    clear,
   input  logic                    shift_en,
   input  logic                    below_in,
   input  lag_pkg::col_window_type left_win,
   input  lag_pkg::col_window_type right_win,
   output lag_pkg::col_window_type own_win,
   output logic                    next_alive
);

   logic                       above_ff;
   logic                       mid_ff;
   logic [lag_pkg::NBR_W-1:0]  count;

   always_ff @(posedge clock) begin
      if (clear) begin
         above_ff <= 1'b0;
         mid_ff   <= 1'b0;
      end else if (shift_en) begin
         above_ff <= mid_ff;
         mid_ff   <= below_in;
      end
   end

   assign own_win.above = above_ff;
   assign own_win.mid   = mid_ff;
   assign own_win.below = below_in;

   always_comb begin
      count = {3'b000, left_win.above} + {3'b000, left_win.mid} + {3'b000, left_win.below}
            + {3'b000, above_ff} + {3'b000, below_in}
            + {3'b000, right_win.above} + {3'b000, right_win.mid}
            + {3'b000, right_win.below};
      next_alive = (count == lag_pkg::BIRTH_COUNT)
                || (mid_ff && (count == lag_pkg::STAY_COUNT));
   end

endmodule

/* rtl/core/life_automaton_grid.sv */
// life grid (b3/s23) with previous-generation store, swept one row per cycle
// set, clear and read: cell state, then finish registers response; idle takes next request
// advance: the rows sweep in phase order through the column cells, then the finish state
// registers the response; the live-grid memory's single write port sets one row per cycle
// reset is synchronous; per-row valid bits make both grids read dead at once, no clearing pass
module life_automaton_grid #(
   parameter int GRID_ROWS = lag_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = lag_pkg::DEF_GRID_COLS
) (
   input  logic      clock,
   input  logic      reset,
   lag_req_if.sink   req_chan,
   lag_rsp_if.source rsp_chan
);

   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int COL_W = $clog2(GRID_COLS);
   localparam int PH_W  = $clog2(GRID_ROWS + 2);
   localparam logic [PH_W-1:0] PH_LAST  = PH_W'(GRID_ROWS + 1);
   localparam logic [PH_W-1:0] PH_ROWS  = PH_W'(GRID_ROWS);
   localparam logic [PH_W-1:0] PH_ONE   = PH_W'(1);
   localparam logic [PH_W-1:0] PH_TWO   = PH_W'(2);

   lag_pkg::state_type state_ff, state_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   lag_pkg::func_type  func_ff;
   logic [lag_pkg::ADDR_W-1:0] row_ff;
   logic [lag_pkg::ADDR_W-1:0] col_ff;
   logic               pend_alive_ff, pend_alive_in;
   logic               pend_was_ff, pend_was_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_alive_ff, rsp_alive_in;
   logic               rsp_was_ff, rsp_was_in;

   logic               accept;
   logic               out_free;
   logic               in_range;
   logic [ROW_W-1:0]   row_idx;
   logic [COL_W-1:0]   col_idx;
   logic [ROW_W-1:0]   req_row_idx;

   logic               live_rd_en, prev_rd_en;
   logic [ROW_W-1:0]   live_rd_addr;
   logic [GRID_COLS-1:0] live_rd_data, prev_rd_data;
   logic               live_wr_en, prev_wr_en;
   logic [ROW_W-1:0]   live_wr_addr, prev_wr_addr;
   logic [GRID_COLS-1:0] live_wr_data;
   logic [GRID_COLS-1:0] mod_row;

   logic               win_clear, win_shift;
   logic [GRID_COLS-1:0] below_bits;
   logic [GRID_COLS-1:0] next_row;
   lag_pkg::col_window_type win [GRID_COLS];

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_row_idx = ROW_W'(32'(req_chan.cell_row));
   assign row_idx     = ROW_W'(32'(row_ff));
   assign col_idx     = COL_W'(32'(col_ff));
   assign in_range    = (32'(row_ff) < GRID_ROWS) && (32'(col_ff) < GRID_COLS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lag_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (lag_pkg::func_type'(req_chan.func) == lag_pkg::FUNC_ADVANCE)
                        ? lag_pkg::ST_ADVANCE : lag_pkg::ST_CELL;
            end
         end
         lag_pkg::ST_CELL:    state_in = lag_pkg::ST_FINISH;
         lag_pkg::ST_ADVANCE: begin
            if (phase_ff == PH_LAST) begin
               state_in = lag_pkg::ST_FINISH;
            end
         end
         lag_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = lag_pkg::ST_IDLE;
            end
         end
         default: state_in = lag_pkg::ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      req_chan.ready = (state_ff == lag_pkg::ST_IDLE);
      phase_in       = '0;
      live_rd_en     = 1'b0;
      live_rd_addr   = req_row_idx;
      prev_rd_en     = 1'b0;
      live_wr_en     = 1'b0;
      live_wr_addr   = row_idx;
      live_wr_data   = mod_row;
      prev_wr_en     = 1'b0;
      prev_wr_addr   = ROW_W'(phase_ff - PH_ONE);
      below_bits     = '0;
      win_clear      = 1'b0;
      win_shift      = 1'b0;
      pend_alive_in  = pend_alive_ff;
      pend_was_in    = pend_was_ff;
      unique case (state_ff)
         lag_pkg::ST_IDLE: begin
            live_rd_en = accept;
            prev_rd_en = accept;
            win_clear  = accept;
            if (accept) begin
               pend_alive_in = 1'b0;
               pend_was_in   = 1'b0;
            end
         end
         lag_pkg::ST_CELL: begin
            live_wr_en    = in_range && ((func_ff == lag_pkg::FUNC_SET)
                                      || (func_ff == lag_pkg::FUNC_CLEAR));
            pend_alive_in = in_range && mod_row[col_idx];
            pend_was_in   = in_range && prev_rd_data[col_idx];
         end
         lag_pkg::ST_ADVANCE: begin
            phase_in     = phase_ff + PH_ONE;
            win_shift    = 1'b1;
            live_rd_en   = (phase_ff < PH_ROWS);
            live_rd_addr = ROW_W'(phase_ff);
            // old row phase-1 arrives from the live store
            if ((phase_ff >= PH_ONE) && (phase_ff <= PH_ROWS)) begin
               below_bits = live_rd_data;
               prev_wr_en = 1'b1;
            end
            // new row phase-2 is complete once its lower neighbor is in
            live_wr_en   = (phase_ff >= PH_TWO);
            live_wr_addr = ROW_W'(phase_ff - PH_TWO);
            live_wr_data = next_row;
         end
         lag_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // set or clear the addressed bit in the fetched row
   always_comb begin
      mod_row = live_rd_data;
      if (func_ff == lag_pkg::FUNC_SET) begin
         mod_row[col_idx] = 1'b1;
      end else if (func_ff == lag_pkg::FUNC_CLEAR) begin
         mod_row[col_idx] = 1'b0;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_alive_in = rsp_alive_ff;
      rsp_was_in   = rsp_was_ff;
      if ((state_ff == lag_pkg::ST_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_alive_in = pend_alive_ff;
         rsp_was_in   = pend_was_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lag_pkg::ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= lag_pkg::func_type'(req_chan.func);
         row_ff  <= req_chan.cell_row;
         col_ff  <= req_chan.cell_col;
      end
      pend_alive_ff <= pend_alive_in;
      pend_was_ff   <= pend_was_in;
      rsp_alive_ff  <= rsp_alive_in;
      rsp_was_ff    <= rsp_was_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.alive     = rsp_alive_ff;
   assign rsp_chan.was_alive = rsp_was_ff;

   lag_row_store #(
      .ROWS (GRID_ROWS),
      .COLS (GRID_COLS)
   ) u_live (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (live_rd_en),
      .rd_addr (live_rd_addr),
      .rd_data (live_rd_data),
      .wr_en   (live_wr_en),
      .wr_addr (live_wr_addr),
      .wr_data (live_wr_data)
   );

   lag_row_store #(
      .ROWS (GRID_ROWS),
      .COLS (GRID_COLS)
   ) u_prev (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (prev_rd_en),
      .rd_addr (req_row_idx),
      .rd_data (prev_rd_data),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (live_rd_data)
   );

   // row of column cells; edge columns see dead neighbors
   for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
      lag_pkg::col_window_type left_win, right_win;

      if (c == 0) begin : g_left_edge
         assign left_win = '0;
      end else begin : g_left
         assign left_win = win[c-1];
      end

      if (c == GRID_COLS - 1) begin : g_right_edge
         assign right_win = '0;
      end else begin : g_right
         assign right_win = win[c+1];
      end

      lag_cell u_cell (
         .clock      (clock),
         .clear      (win_clear),
         .shift_en   (win_shift),
         .below_in   (below_bits[c]),
         .left_win   (left_win),
         .right_win  (right_win),
         .own_win    (win[c]),
         .next_alive (next_row[c])
      );
   end

endmodule
